// ===== sv/brps_pkg.sv =====
// Shared types and constants for the bitmap region pixel streamer.
// No dependencies; every other file in this folder imports this package.
package brps_pkg;

    localparam int LOGICAL_COLS_DEF = 120;
    localparam int LOGICAL_ROWS_DEF = 160;
    localparam int SCALE_DEF        = 2;

    localparam int COL_W       = 7;
    localparam int ROW_W       = 8;
    localparam int FADDR_W     = 12;
    localparam int BYTE_W      = 8;
    localparam int JOB_ADDR_W  = 15;
    localparam int S_TDATA_W   = 56;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int START_BYTES = 11;
    localparam int CNT_W       = 4;

    localparam logic [BYTE_W-1:0] PIX_ON        = 8'hFF;
    localparam logic [BYTE_W-1:0] PIX_OFF       = 8'h00;
    localparam logic [BYTE_W-1:0] COL_OP_RESET  = 8'd42;
    localparam logic [BYTE_W-1:0] PAGE_OP_RESET = 8'd43;
    localparam logic [BYTE_W-1:0] MEM_OP_RESET  = 8'd44;

    typedef logic [1:0] action_t;
    localparam action_t ACT_WRITE = 2'd0;
    localparam action_t ACT_START = 2'd1;
    localparam action_t ACT_STEP  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_COLUMN_OP = 2'd0;
    localparam cfg_idx_t REG_PAGE_OP   = 2'd1;
    localparam cfg_idx_t REG_MEMWR_OP  = 2'd2;

    typedef enum logic [1:0] {
        JOB_WRITE = 2'd0,
        JOB_START = 2'd1,
        JOB_STEP  = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t             kind;
        logic [JOB_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]     data;
        logic [2:0]            bit_sel;
        logic                  done;
        logic [COL_W-1:0]      left;
        logic [ROW_W-1:0]      top;
        logic [COL_W-1:0]      right;
        logic [ROW_W-1:0]      bottom;
    } job_t;

    typedef struct packed {
        logic [BYTE_W-1:0] col_op;
        logic [BYTE_W-1:0] page_op;
        logic [BYTE_W-1:0] mem_op;
    } opcodes_t;

endpackage

// ===== sv/bitmap_region_pixel_streamer_top.sv =====
// Top level of the bitmap region pixel streamer: opcode registers, front end,
// job queue and back end. Depends on brps_pkg, brps_front, brps_queue, brps_back.
//
//  channel  | ports            | transaction
//  ---------+------------------+----------------------------------------------
//  input    | s_tvalid/tready  | one action: frame write, window start or step
//  result   | m_tvalid/tready  | one panel byte with command/done flags
//  config   | cfg_wr_en        | one opcode register write, no wait
//
// A step yields 2*SCALE bytes at one byte per cycle from the back end output
// register while m_tready allows; a start yields 11 bytes, a write none.
// The frame memory read adds no bubble: it is issued when the job is popped.
// Reset is synchronous, active low; frame memory contents are not cleared.
// The input side stalls only when the four-entry job queue is full.
module bitmap_region_pixel_streamer_top import brps_pkg::*; #(
    parameter int LOGICAL_COLS = LOGICAL_COLS_DEF,
    parameter int LOGICAL_ROWS = LOGICAL_ROWS_DEF,
    parameter int SCALE        = SCALE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // frame_address, frame_data, left_col, top_row, right_col, bottom_row, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_byte
    output logic [M_TDATA_W-1:0] m_tdata,
    // is_command, region_done
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata
);

    opcodes_t opcodes_reg, opcodes_next;
    logic     q_full, q_push, q_pop, head_valid;
    job_t     q_job, head_job;

    always_comb begin
        opcodes_next = opcodes_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COLUMN_OP: opcodes_next.col_op  = cfg_wdata;
                REG_PAGE_OP:   opcodes_next.page_op = cfg_wdata;
                REG_MEMWR_OP:  opcodes_next.mem_op  = cfg_wdata;
                default:       opcodes_next         = opcodes_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opcodes_reg.col_op  <= COL_OP_RESET;
            opcodes_reg.page_op <= PAGE_OP_RESET;
            opcodes_reg.mem_op  <= MEM_OP_RESET;
        end else begin
            opcodes_reg <= opcodes_next;
        end
    end

    brps_front #(
        .LOGICAL_COLS(LOGICAL_COLS),
        .LOGICAL_ROWS(LOGICAL_ROWS),
        .SCALE       (SCALE)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_job)
    );

    brps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_job),
        .full      (q_full),
        .pop       (q_pop),
        .head_job  (head_job),
        .head_valid(head_valid)
    );

    brps_back #(
        .LOGICAL_COLS(LOGICAL_COLS),
        .LOGICAL_ROWS(LOGICAL_ROWS),
        .SCALE       (SCALE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .head_valid(head_valid),
        .q_pop     (q_pop),
        .opcodes   (opcodes_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sv/brps_front.sv =====
// Front end: accepts input transactions, tracks window/cursor state and
// turns each valid item into a back-end job. Depends on brps_pkg.
module brps_front import brps_pkg::*; #(
    parameter int LOGICAL_COLS = LOGICAL_COLS_DEF,
    parameter int LOGICAL_ROWS = LOGICAL_ROWS_DEF,
    parameter int SCALE        = SCALE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output job_t                 q_job
);

    localparam int FRAME_BYTES = (LOGICAL_COLS * LOGICAL_ROWS + 7) / 8;
    localparam int IDX_W       = $clog2(LOGICAL_COLS * LOGICAL_ROWS);
    localparam int REP_W       = (SCALE > 1) ? $clog2(SCALE) : 1;

    logic                 busy_reg, busy_next;
    logic [COL_W-1:0]     win_left_reg, win_left_next;
    logic [COL_W-1:0]     win_right_reg, win_right_next;
    logic [ROW_W-1:0]     win_bottom_reg, win_bottom_next;
    logic [COL_W-1:0]     cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]     cur_row_reg, cur_row_next;
    logic [REP_W-1:0]     rep_reg, rep_next;

    action_t              action;
    logic [FADDR_W-1:0]   f_addr;
    logic [BYTE_W-1:0]    f_data;
    logic [COL_W-1:0]     f_left, f_right;
    logic [ROW_W-1:0]     f_top, f_bottom;
    logic                 accept, win_bad, addr_ok;
    logic [IDX_W-1:0]     idx;
    logic                 row_end, rep_end, final_px;

    assign action   = s_tuser;
    assign f_addr   = s_tdata[11:0];
    assign f_data   = s_tdata[19:12];
    assign f_left   = s_tdata[26:20];
    assign f_top    = s_tdata[34:27];
    assign f_right  = s_tdata[41:35];
    assign f_bottom = s_tdata[49:42];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign win_bad = (f_left > f_right) || (f_top > f_bottom)
                   || (32'(f_right) >= 32'(LOGICAL_COLS))
                   || (32'(f_bottom) >= 32'(LOGICAL_ROWS));
    assign addr_ok = 32'(f_addr) < 32'(FRAME_BYTES);

    assign idx      = IDX_W'(32'(cur_row_reg) * 32'(LOGICAL_COLS)) + IDX_W'(cur_col_reg);
    assign row_end  = cur_col_reg == win_right_reg;
    assign rep_end  = 32'(rep_reg) >= 32'(SCALE - 1);
    assign final_px = row_end && rep_end && (cur_row_reg >= win_bottom_reg);

    always_comb begin
        busy_next       = busy_reg;
        win_left_next   = win_left_reg;
        win_right_next  = win_right_reg;
        win_bottom_next = win_bottom_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        rep_next        = rep_reg;
        q_push          = 1'b0;
        q_job           = '0;
        q_job.data      = f_data;
        q_job.left      = f_left;
        q_job.top       = f_top;
        q_job.right     = f_right;
        q_job.bottom    = f_bottom;
        if (accept) begin
            priority if (action == ACT_WRITE) begin
                q_job.kind = JOB_WRITE;
                q_job.addr = JOB_ADDR_W'(f_addr);
                q_push     = addr_ok;
            end else if (action == ACT_START) begin
                q_job.kind = JOB_START;
                if (!win_bad) begin
                    q_push          = 1'b1;
                    busy_next       = 1'b1;
                    win_left_next   = f_left;
                    win_right_next  = f_right;
                    win_bottom_next = f_bottom;
                    cur_col_next    = f_left;
                    cur_row_next    = f_top;
                    rep_next        = '0;
                end
            end else if (action == ACT_STEP) begin
                q_job.kind    = JOB_STEP;
                q_job.addr    = JOB_ADDR_W'(idx >> 3);
                q_job.bit_sel = 3'd7 - idx[2:0];
                q_job.done    = final_px;
                if (busy_reg) begin
                    q_push = 1'b1;
                    if (final_px) begin
                        busy_next = 1'b0;
                    end
                    if (row_end) begin
                        cur_col_next = win_left_reg;
                        if (rep_end) begin
                            rep_next     = '0;
                            cur_row_next = cur_row_reg + 1'b1;
                        end else begin
                            rep_next = rep_reg + 1'b1;
                        end
                    end else begin
                        cur_col_next = cur_col_reg + 1'b1;
                    end
                end
            end else begin
                q_push = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            win_left_reg   <= '0;
            win_right_reg  <= '0;
            win_bottom_reg <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            rep_reg        <= '0;
        end else begin
            busy_reg       <= busy_next;
            win_left_reg   <= win_left_next;
            win_right_reg  <= win_right_next;
            win_bottom_reg <= win_bottom_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            rep_reg        <= rep_next;
        end
    end

endmodule

// ===== sv/brps_queue.sv =====
// Short job queue between front and back ends.
// Depends on brps_pkg for the job type and depth.
module brps_queue import brps_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic head_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/brps_back.sv =====
// Back end: holds the frame memory, executes jobs and drives the output register.
// Depends on brps_pkg.
module brps_back import brps_pkg::*; #(
    parameter int LOGICAL_COLS = LOGICAL_COLS_DEF,
    parameter int LOGICAL_ROWS = LOGICAL_ROWS_DEF,
    parameter int SCALE        = SCALE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  job_t                 head_job,
    input  logic                 head_valid,
    output logic                 q_pop,
    input  opcodes_t             opcodes,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int FRAME_BYTES = (LOGICAL_COLS * LOGICAL_ROWS + 7) / 8;
    localparam int MEM_AW      = $clog2(FRAME_BYTES);
    localparam int STEP_BYTES  = 2 * SCALE;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EMIT = 2'b10
    } back_state_t;

    back_state_t          state_reg, state_next;
    job_t                 cur_reg, cur_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [BYTE_W-1:0]    frame_mem [FRAME_BYTES];
    logic [BYTE_W-1:0]    rd_q;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                 cmd_reg, cmd_next;
    logic                 done_reg, done_next;
    logic                 last_reg, last_next;

    logic                 out_free, load, at_end, done_emit;
    logic [15:0]          col_first, col_last, row_first, row_last;
    logic [BYTE_W-1:0]    start_byte, step_byte;
    logic                 start_cmd;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign load      = (state_reg == B_EMIT) && out_free;
    assign at_end    = (cur_reg.kind == JOB_START) ? (cnt_reg == CNT_W'(START_BYTES - 1))
                                                   : (cnt_reg == CNT_W'(STEP_BYTES - 1));
    assign done_emit = load && at_end;
    assign q_pop     = head_valid && ((state_reg == B_IDLE) || done_emit);

    assign col_first = 16'(32'(cur_reg.left) * SCALE);
    assign col_last  = 16'((32'(cur_reg.right) + 32'd1) * SCALE - 1);
    assign row_first = 16'(32'(cur_reg.top) * SCALE);
    assign row_last  = 16'((32'(cur_reg.bottom) + 32'd1) * SCALE - 1);
    assign step_byte = rd_q[cur_reg.bit_sel] ? PIX_ON : PIX_OFF;

    always_comb begin
        start_cmd = 1'b0;
        unique case (cnt_reg)
            4'd0: begin
                start_byte = opcodes.col_op;
                start_cmd  = 1'b1;
            end
            4'd1: start_byte = col_first[15:8];
            4'd2: start_byte = col_first[7:0];
            4'd3: start_byte = col_last[15:8];
            4'd4: start_byte = col_last[7:0];
            4'd5: begin
                start_byte = opcodes.page_op;
                start_cmd  = 1'b1;
            end
            4'd6: start_byte = row_first[15:8];
            4'd7: start_byte = row_first[7:0];
            4'd8: start_byte = row_last[15:8];
            4'd9: start_byte = row_last[7:0];
            4'd10: begin
                start_byte = opcodes.mem_op;
                start_cmd  = 1'b1;
            end
            default: start_byte = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        cmd_next      = cmd_reg;
        done_next     = done_reg;
        last_next     = last_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            last_next     = at_end;
            if (cur_reg.kind == JOB_START) begin
                m_tdata_next = start_byte;
                cmd_next     = start_cmd;
                done_next    = 1'b0;
            end else begin
                m_tdata_next = step_byte;
                cmd_next     = 1'b0;
                done_next    = at_end && cur_reg.done;
            end
            cnt_next = cnt_reg + 1'b1;
            if (at_end) begin
                state_next = B_IDLE;
            end
        end
        if (q_pop) begin
            cur_next   = head_job;
            cnt_next   = '0;
            state_next = (head_job.kind == JOB_WRITE) ? B_IDLE : B_EMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && head_job.kind == JOB_WRITE) begin
            frame_mem[head_job.addr[MEM_AW-1:0]] <= head_job.data;
        end
        if (q_pop && head_job.kind == JOB_STEP) begin
            rd_q <= frame_mem[head_job.addr[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
        cmd_reg     <= cmd_next;
        done_reg    <= done_next;
        last_reg    <= last_next;
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = {done_reg, cmd_reg};
    assign m_tlast  = last_reg;

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && done_reg |-> last_reg)
        else $error("region_done without tlast");

    a_cmd_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && cmd_reg |-> !done_reg)
        else $error("command byte flagged region_done");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_EMIT |-> cnt_reg <= CNT_W'(START_BYTES - 1))
        else $error("byte counter overran");

endmodule
